>>> sv/ptch_pkg.sv
// shared types and constants of the probe class histogram
package ptch_pkg;

  localparam int unsigned NUM_PROBE_FIELDS = 6;
  localparam int unsigned MISMATCH_W = 11;
  localparam int unsigned CODE_W = 10;
  localparam int unsigned OUT_COUNT_W = 16;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // operation codes of an input beat; the spare code behaves as a read
  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_READ     = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_SPARE    = 2'd3
  } op_code_t;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_PROBE_COUNT = 2'd0,
    REG_ALLOWED     = 2'd1,
    REG_GREYZONE    = 2'd2,
    REG_OUTSIDE     = 2'd3
  } reg_index_t;

  // base-3 digit weights, probe 0 least significant
  localparam logic [CODE_W-1:0] POW3 [NUM_PROBE_FIELDS] = '{
    10'd1, 10'd3, 10'd9, 10'd27, 10'd81, 10'd243
  };

  typedef struct packed {
    logic [1:0]            operation;
    logic                  species_present;
    logic                  is_marked;
    logic [MISMATCH_W-1:0] mismatch_p0;
    logic [MISMATCH_W-1:0] mismatch_p1;
    logic [MISMATCH_W-1:0] mismatch_p2;
    logic [MISMATCH_W-1:0] mismatch_p3;
    logic [MISMATCH_W-1:0] mismatch_p4;
    logic [MISMATCH_W-1:0] mismatch_p5;
    logic [CODE_W-1:0]     bin_index;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0]      code;
    logic [OUT_COUNT_W-1:0] marked_count;
    logic [OUT_COUNT_W-1:0] unmarked_count;
  } out_beat_t;

endpackage

>>> sv/ptch_ram.sv
// generic single-clock ram, one write port and one registered read port
module ptch_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 729
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/ptch_classify.sv
// per-probe ternary classification and base-3 code forming
module ptch_classify #(
  parameter int unsigned MAX_PROBES = 6
) (
  input  ptch_pkg::in_beat_t           beat,
  input  logic [2:0]                   probe_count,
  input  logic [23:0]                  allowed_mismatches,
  input  logic [7:0]                   greyzone,
  input  logic [7:0]                   outside_difference,
  output logic [ptch_pkg::CODE_W-1:0]  code
);
  import ptch_pkg::*;

  localparam logic [2:0] MaxP = 3'(MAX_PROBES);

  logic [MISMATCH_W-1:0] mism [NUM_PROBE_FIELDS];
  logic [2:0]            active;

  assign mism[0] = beat.mismatch_p0;
  assign mism[1] = beat.mismatch_p1;
  assign mism[2] = beat.mismatch_p2;
  assign mism[3] = beat.mismatch_p3;
  assign mism[4] = beat.mismatch_p4;
  assign mism[5] = beat.mismatch_p5;

  assign active = (probe_count > MaxP) ? MaxP : probe_count;

  always_comb begin
    logic [8:0]        low_lim;
    logic [9:0]        high_lim;
    logic [CODE_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < NUM_PROBE_FIELDS; j++) begin
      // allowed count is integral, scaled by 16 to match the mismatch format
      low_lim  = {1'b0, allowed_mismatches[4*j +: 4], 4'b0000} + {1'b0, greyzone};
      high_lim = {1'b0, low_lim} + {2'b00, outside_difference};
      if (3'(j) < active) begin
        if (mism[j] <= {2'b00, low_lim}) begin
          acc = acc;
        end else if (mism[j] <= {1'b0, high_lim}) begin
          acc = acc + POW3[j];
        end else begin
          acc = acc + CODE_W'({POW3[j], 1'b0});
        end
      end
    end
    code = acc;
  end

endmodule

>>> sv/probe_ternary_class_histogram_core.sv
// top level of the probe class histogram: config registers, bin store and read-modify-write
//
//   channel | direction | handshake             | beat
//   in_     | input     | in_valid / in_stall   | ptch_pkg::in_beat_t
//   out_    | output    | out_valid / out_stall | ptch_pkg::out_beat_t
//   cfg_    | input     | apb psel/penable      | 32-bit register write / read
//
// from acceptance to result a beat passes through a bin read, then modify and write back;
// a new beat is accepted in the cycle its predecessor writes back, so one beat per cycle
// is sustained when the output is not stalled; a write-to-read forward covers same-bin beats
// after reset a clearing pass zeroes all 3**MAX_PROBES bins (729 bins at the default),
// one per cycle, with in_stall held high; config writes are taken throughout
// a stalled result holds the finished beat in the read stage and stalls the input
module probe_ternary_class_histogram_core #(
  parameter int unsigned MAX_PROBES = 6,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ptch_pkg::in_beat_t                in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output ptch_pkg::out_beat_t               out_data,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ptch_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ptch_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ptch_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import ptch_pkg::*;

  localparam int unsigned BinDepth = 3 ** MAX_PROBES;
  localparam int unsigned AddrW = $clog2(BinDepth);
  localparam int unsigned WordW = 2 * COUNT_BITS;
  localparam int unsigned ExtW = COUNT_BITS + OUT_COUNT_W;
  localparam logic [CODE_W:0] DepthLim = (CODE_W+1)'(BinDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(BinDepth - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  // ---------------- configuration registers ----------------
  logic [2:0]  probe_count_r;
  logic [23:0] allowed_r;
  logic [7:0]  greyzone_r;
  logic [7:0]  outside_r;
  reg_index_t  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_index_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_count_r <= 3'd1;
      allowed_r     <= '0;
      greyzone_r    <= '0;
      outside_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROBE_COUNT: probe_count_r <= cfg_pwdata[2:0];
        REG_ALLOWED:     allowed_r     <= cfg_pwdata[23:0];
        REG_GREYZONE:    greyzone_r    <= cfg_pwdata[7:0];
        REG_OUTSIDE:     outside_r     <= cfg_pwdata[7:0];
        default:         probe_count_r <= probe_count_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROBE_COUNT: cfg_prdata = {29'd0, probe_count_r};
      REG_ALLOWED:     cfg_prdata = {8'd0, allowed_r};
      REG_GREYZONE:    cfg_prdata = {24'd0, greyzone_r};
      REG_OUTSIDE:     cfg_prdata = {24'd0, outside_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------- classification at acceptance ----------------
  logic [CODE_W-1:0] class_code;

  ptch_classify #(
    .MAX_PROBES (MAX_PROBES)
  ) u_classify (
    .beat               (in_data),
    .probe_count        (probe_count_r),
    .allowed_mismatches (allowed_r),
    .greyzone           (greyzone_r),
    .outside_difference (outside_r),
    .code               (class_code)
  );

  op_code_t          in_op;
  logic [CODE_W-1:0] in_code;
  logic              in_inrange;

  assign in_op      = op_code_t'(in_data.operation);
  assign in_code    = (in_op == OP_CLASSIFY) ? class_code : in_data.bin_index;
  assign in_inrange = ({1'b0, in_code} < DepthLim);

  // ---------------- control ----------------
  state_t             state_r, state_nxt;
  logic [AddrW-1:0]   clr_addr_r, clr_addr_nxt;
  logic               out_free;
  logic               take;
  logic               accept;
  logic               leave;

  // read-stage registers of the beat in flight
  logic               is_class_r;
  logic               is_clear_r;
  logic               present_r;
  logic               marked_r;
  logic [CODE_W-1:0]  code_r;
  logic               inrange_r;
  logic [AddrW-1:0]   addr_r;

  // forward of the word written in the same edge as the next read
  logic               fwd_r;
  logic [WordW-1:0]   fwd_data_r;

  logic               out_valid_r;
  out_beat_t          out_data_r;

  assign out_free = !out_valid_r || !out_stall;
  assign leave    = (state_r == ST_READ) && out_free;
  assign take     = (state_r == ST_IDLE) || leave;
  assign accept   = in_valid && take;
  assign in_stall = !take;

  // ---------------- bin store ----------------
  logic [WordW-1:0] rd_word;
  logic [WordW-1:0] cur_word;
  logic [WordW-1:0] new_word;
  logic             wb_en;
  logic             ram_wr_en;
  logic [AddrW-1:0] ram_wr_addr;
  logic [WordW-1:0] ram_wr_data;

  assign ram_wr_en   = (state_r == ST_CLEAR) || wb_en;
  assign ram_wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wr_data = (state_r == ST_CLEAR) ? '0 : new_word;

  ptch_ram #(
    .WIDTH (WordW),
    .DEPTH (BinDepth)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (in_code[AddrW-1:0]),
    .rd_data (rd_word)
  );

  // ---------------- modify ----------------
  logic [COUNT_BITS-1:0] cur_m, cur_u, new_m, new_u;
  logic [ExtW-1:0]       ext_m, ext_u;

  assign cur_word = fwd_r ? fwd_data_r : rd_word;
  assign cur_m    = cur_word[WordW-1:COUNT_BITS];
  assign cur_u    = cur_word[COUNT_BITS-1:0];

  always_comb begin
    new_m = cur_m;
    new_u = cur_u;
    if (is_clear_r) begin
      new_m = '0;
      new_u = '0;
    end else if (is_class_r && present_r) begin
      // saturating increment of the selected counter
      if (marked_r) begin
        if (cur_m != '1) begin
          new_m = cur_m + COUNT_BITS'(1);
        end
      end else begin
        if (cur_u != '1) begin
          new_u = cur_u + COUNT_BITS'(1);
        end
      end
    end
  end

  assign new_word = {new_m, new_u};
  assign wb_en    = leave && inrange_r;
  assign ext_m    = ExtW'(new_m);
  assign ext_u    = ExtW'(new_u);

  // ---------------- sequencing ----------------
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AddrW'(1);
        if (clr_addr_r == LastAddr) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (leave) begin
          state_nxt = accept ? ST_READ : ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (leave) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        // same bin written back at this edge: ram returns the stale word
        fwd_r <= wb_en && (in_code[AddrW-1:0] == addr_r);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_class_r <= (in_op == OP_CLASSIFY);
      is_clear_r <= (in_op == OP_CLEAR);
      present_r  <= in_data.species_present;
      marked_r   <= in_data.is_marked;
      code_r     <= in_code;
      inrange_r  <= in_inrange;
      addr_r     <= in_code[AddrW-1:0];
      fwd_data_r <= new_word;
    end
    if (leave) begin
      out_data_r.code           <= code_r;
      out_data_r.marked_count   <= inrange_r ? ext_m[OUT_COUNT_W-1:0] : '0;
      out_data_r.unmarked_count <= inrange_r ? ext_u[OUT_COUNT_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
